FILE: hdl/bilateral_filter_gray_defines.svh
// assertion macros for the filter top level
`ifndef BILATERAL_FILTER_GRAY_DEFINES_SVH
`define BILATERAL_FILTER_GRAY_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BFG_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define BFG_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hdl/bfg_pkg.sv
package bfg_pkg;

    localparam int RADIUS     = 4;
    localparam int TAPS       = 2 * RADIUS + 1;
    localparam int SLOTS      = 2 * RADIUS;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int LS_ABITS   = SLOT_BITS + COL_BITS;
    localparam int TAP_BITS   = $clog2(TAPS);
    localparam int K_BITS     = $clog2(RADIUS + 1);
    localparam int WB         = 16;
    localparam int SHIFT_A    = (WB > 16) ? 2 * (WB - 16) : 0;
    localparam int SHIFT_B    = (WB > 16) ? (WB - 16) : 0;
    localparam int SP_BITS    = 2 * WB - SHIFT_A;
    localparam int W_BITS     = SP_BITS + WB - SHIFT_B;
    localparam int ACC_GROW   = $clog2(TAPS * TAPS);
    localparam int DEN_BITS   = W_BITS + ACC_GROW;
    localparam int NUM_BITS   = W_BITS + 8 + ACC_GROW;
    localparam int MAC_STEPS  = TAPS * TAPS;
    localparam int CNT_BITS   = $clog2(MAC_STEPS + 2);

    typedef logic [1:0]    op_t;
    typedef logic [7:0]    pixel_t;
    typedef logic [WB-1:0] weight_t;

    localparam op_t OP_SPATIAL = 2'd0;
    localparam op_t OP_RANGE   = 2'd1;
    localparam op_t OP_PIXEL   = 2'd2;
    localparam op_t OP_FLUSH   = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic                take;
        logic                rd_en;
        logic                rd_cap;
        logic [TAP_BITS-1:0] rd_tap;
        logic                store;
        logic                win_load;
        logic                win_repl;
        logic                mac_clear;
        logic                mac_step;
        logic                col_rot;
        logic [TAP_BITS-1:0] ti;
        logic [TAP_BITS-1:0] tj;
        logic                div_init;
        logic                div_step;
        logic                out_load;
        logic                out_last;
        logic                out_done;
        logic [K_BITS-1:0]   ext_k;
        logic                pos_update;
    } cmd_t;

    typedef struct packed {
        logic in_frame;
        logic row_end;
        logic frame_end;
        logic emit_main;
        logic ext_ok;
        logic out_free;
    } status_t;

endpackage

FILE: hdl/bfg_ctrl.sv
module bfg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  bfg_pkg::op_t     s_op,
    output logic             s_tready,
    input  bfg_pkg::status_t st,
    output bfg_pkg::cmd_t    cmd
);
    import bfg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_MAC0 = 4'd3;
    localparam logic [3:0] S_MAC  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_REPL = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [TAP_BITS-1:0] ti_reg, ti_next, tj_reg, tj_next;
    logic [K_BITS-1:0]   k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ti_reg    <= '0;
            tj_reg    <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ti_reg    <= ti_next;
            tj_reg    <= tj_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ti_next    = ti_reg;
        tj_next    = tj_reg;
        k_next     = k_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.ext_k  = k_reg;
        cmd.rd_tap = cnt_reg[TAP_BITS-1:0];
        cmd.ti     = ti_reg;
        cmd.tj     = tj_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                cnt_next = '0;
                if (s_tvalid && (s_op == OP_PIXEL || (s_op == OP_FLUSH && !st.in_frame)))
                    state_next = S_READ;
            end
            S_READ: begin
                cmd.rd_en  = (cnt_reg < CNT_BITS'(TAPS));
                cmd.rd_cap = (cnt_reg != '0);
                if (cnt_reg == CNT_BITS'(TAPS)) begin
                    state_next = S_UPD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UPD: begin
                cmd.store    = 1'b1;
                cmd.win_load = 1'b1;
                k_next       = '0;
                if (st.emit_main) begin
                    state_next = S_MAC0;
                end else if (st.row_end) begin
                    k_next     = K_BITS'(1);
                    state_next = S_REPL;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MAC0: begin
                cmd.mac_clear = 1'b1;
                cnt_next      = '0;
                ti_next       = '0;
                tj_next       = '0;
                state_next    = S_MAC;
            end
            S_MAC: begin
                cmd.mac_step = (cnt_reg < CNT_BITS'(MAC_STEPS));
                cmd.col_rot  = (ti_reg == TAP_BITS'(TAPS - 1));
                if (cmd.mac_step) begin
                    if (cmd.col_rot) begin
                        ti_next = '0;
                        tj_next = tj_reg + 1'b1;
                    end else begin
                        ti_next = ti_reg + 1'b1;
                    end
                end
                if (cnt_reg == CNT_BITS'(MAC_STEPS + 1)) begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                if (cnt_reg == CNT_BITS'(8)) begin
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT: begin
                cmd.out_last = (k_reg == '0) ? !st.row_end : (k_reg == K_BITS'(RADIUS));
                cmd.out_done = cmd.out_last && st.row_end && st.frame_end;
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    if (cmd.out_last) begin
                        state_next = S_FIN;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_REPL;
                    end
                end
            end
            S_REPL: begin
                cmd.win_repl = 1'b1;
                if (st.ext_ok) begin
                    state_next = S_MAC0;
                end else if (k_reg == K_BITS'(RADIUS)) begin
                    state_next = S_FIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_FIN: begin
                cmd.pos_update = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/bfg_datapath.sv
module bfg_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      s_tdata,
    input  bfg_pkg::op_t     s_op,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [12:0]      cfg_data,
    input  bfg_pkg::cmd_t    cmd,
    output bfg_pkg::status_t st,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    output logic [0:0]       m_tuser
);
    import bfg_pkg::*;

    logic [11:0]         width_reg;
    logic [ROW_BITS-1:0] height_reg;
    logic [11:0]         w_eff;
    logic [ROW_BITS-1:0] h_eff, h_m1;

    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    pixel_t              pix_reg;

    pixel_t  ls_mem [2**LS_ABITS];
    weight_t range_mem [256];
    weight_t sw_reg [TAPS];

    logic signed [ROW_BITS+1:0] rs;
    logic [ROW_BITS-1:0]        row_cl;
    logic [LS_ABITS-1:0]        rd_addr;
    pixel_t                     rdata_reg;
    logic                       usepix_reg;
    pixel_t                     col_reg_a [TAPS];
    pixel_t                     win_reg [TAPS][TAPS];
    pixel_t                     col8_rot [TAPS];

    pixel_t              centre_reg, tap, tap_diff;
    logic [2*WB-1:0]     sp_full;
    logic [SP_BITS-1:0]  sp_reg;
    weight_t             rw_reg;
    pixel_t              pa_reg, pb_reg;
    logic                va_reg, vb_reg;
    logic [SP_BITS+WB-1:0] w_full;
    logic [W_BITS-1:0]   w_reg;
    logic [W_BITS+7:0]   wp;
    logic [NUM_BITS-1:0] num_reg, rem_reg, dsh_reg;
    logic [DEN_BITS-1:0] den_reg;
    pixel_t              q_reg;

    logic [ROW_BITS-1:0] y_pos;
    logic [COL_BITS-1:0] x_pos;
    pixel_t              opix_reg;
    logic [11:0]         orow_reg;
    logic [COL_BITS-1:0] ocol_reg;
    logic                olast_reg, odone_reg, ovalid_reg;

    // effective image size
    always_comb begin
        if (width_reg == '0)
            w_eff = 12'd1;
        else if (width_reg > 12'(MAX_WIDTH))
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = ROW_BITS'(1);
        else if (height_reg > ROW_BITS'(MAX_HEIGHT))
            h_eff = ROW_BITS'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        h_m1 = h_eff - 1'b1;
    end

    always_comb begin
        st.in_frame  = (row_reg < h_eff);
        st.row_end   = ({1'b0, col_reg} >= (w_eff - 1'b1));
        st.frame_end = (({1'b0, row_reg} + 1'b1) >= ({1'b0, h_eff} + (ROW_BITS+1)'(RADIUS)));
        st.emit_main = (row_reg >= ROW_BITS'(RADIUS)) && (col_reg >= COL_BITS'(RADIUS));
        st.ext_ok    = (row_reg >= ROW_BITS'(RADIUS))
                     && (({1'b0, col_reg} + (COL_BITS+1)'(cmd.ext_k)) >= (COL_BITS+1)'(RADIUS));
        st.out_free  = !ovalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd640;
            height_reg <= ROW_BITS'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_index == CFG_WIDTH)
                width_reg <= cfg_data[11:0];
            if (cfg_valid && cfg_index == CFG_HEIGHT)
                height_reg <= cfg_data;
            if (cmd.pos_update) begin
                if (st.row_end) begin
                    col_reg <= '0;
                    row_reg <= st.frame_end ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // item capture and weight table loads
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg <= s_tdata[31:24];
            if (s_op == OP_SPATIAL && s_tdata[7:0] < 8'(TAPS))
                sw_reg[s_tdata[TAP_BITS-1:0]] <= weight_t'(s_tdata[23:8]);
            if (s_op == OP_RANGE)
                range_mem[s_tdata[7:0]] <= weight_t'(s_tdata[23:8]);
        end
    end

    // line store tap rows, clamped to the image
    always_comb begin
        rs = $signed({2'b00, row_reg}) - $signed((ROW_BITS+2)'(SLOTS))
           + $signed((ROW_BITS+2)'(cmd.rd_tap));
        if (rs[ROW_BITS+1])
            row_cl = '0;
        else if (rs[ROW_BITS:0] > {1'b0, h_m1})
            row_cl = h_m1;
        else
            row_cl = rs[ROW_BITS-1:0];
        rd_addr = {row_cl[SLOT_BITS-1:0], col_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && st.in_frame)
            ls_mem[{row_reg[SLOT_BITS-1:0], col_reg}] <= pix_reg;
        if (cmd.rd_en) begin
            rdata_reg  <= ls_mem[rd_addr];
            usepix_reg <= (row_cl == row_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_cap) begin
            for (int t = 0; t < TAPS - 1; t++)
                col_reg_a[t] <= col_reg_a[t+1];
            col_reg_a[TAPS-1] <= usepix_reg ? pix_reg : rdata_reg;
        end
    end

    // window: column k holds the column k places left of the newest
    always_comb begin
        for (int t = 0; t < TAPS - 1; t++)
            col8_rot[t] = win_reg[TAPS-1][t+1];
        col8_rot[TAPS-1] = win_reg[TAPS-1][0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_load) begin
            win_reg[0] <= col_reg_a;
            for (int k = 1; k < TAPS; k++)
                win_reg[k] <= (col_reg == '0) ? col_reg_a : win_reg[k-1];
        end else if (cmd.win_repl) begin
            for (int k = 1; k < TAPS; k++)
                win_reg[k] <= win_reg[k-1];
        end else if (cmd.mac_step) begin
            if (cmd.col_rot) begin
                win_reg[0] <= col8_rot;
                for (int k = 1; k < TAPS; k++)
                    win_reg[k] <= win_reg[k-1];
            end else begin
                win_reg[TAPS-1] <= col8_rot;
            end
        end
    end

    // weight and accumulate pipeline, one tap a cycle
    assign tap      = win_reg[TAPS-1][0];
    assign tap_diff = (tap > centre_reg) ? tap - centre_reg : centre_reg - tap;
    assign sp_full  = sw_reg[cmd.tj] * sw_reg[cmd.ti];
    assign w_full   = sp_reg * rw_reg;
    assign wp       = w_reg * pb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= cmd.mac_step;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_clear)
            centre_reg <= win_reg[RADIUS][RADIUS];
        rw_reg <= range_mem[tap_diff];
        sp_reg <= sp_full[2*WB-1:SHIFT_A];
        pa_reg <= tap;
        w_reg  <= w_full[SP_BITS+WB-1:SHIFT_B];
        pb_reg <= pa_reg;
        if (cmd.mac_clear) begin
            num_reg <= '0;
            den_reg <= '0;
        end else if (vb_reg) begin
            num_reg <= num_reg + NUM_BITS'(wp);
            den_reg <= den_reg + DEN_BITS'(w_reg);
        end
    end

    // restoring divider, the quotient never exceeds eight bits
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= num_reg;
            dsh_reg <= NUM_BITS'(den_reg) << 7;
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[6:0], 1'b1};
            end else begin
                q_reg <= {q_reg[6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // output register
    assign y_pos = row_reg - ROW_BITS'(RADIUS);
    assign x_pos = col_reg + COL_BITS'(cmd.ext_k) - COL_BITS'(RADIUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            opix_reg  <= (den_reg == '0) ? centre_reg : q_reg;
            orow_reg  <= y_pos[11:0];
            ocol_reg  <= x_pos;
            olast_reg <= cmd.out_last;
            odone_reg <= cmd.out_done;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, ocol_reg, orow_reg, opix_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = odone_reg;

endmodule

FILE: hdl/bilateral_filter_gray.sv
// bilateral filter, 9x9 window, 8-bit grayscale, raster order in and out
// a weight load is taken straight from idle; a pixel or flush with no result reads the tap
// column and updates the window, with replicate steps at row end; each result adds mac clear,
// 81 taps and the pipe drain, divider init + 8 steps, output load; a replicated column adds a step
// reset (aresetn low, synchronous) clears position and handshake; size 640x480
// weight tables and line store hold garbage until loaded
`include "bilateral_filter_gray_defines.svh"

module bilateral_filter_gray (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // table_index[7:0], weight_value[23:8], pixel_value[31:24]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // filtered_pixel[7:0], out_row[19:8], out_col[30:20], zero
    output logic        m_tlast,   // last result of the input transfer
    output logic [0:0]  m_tuser,   // frame_done[0]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index, // 0 image_width, 1 image_height
    input  logic [12:0] cfg_data
);
    import bfg_pkg::*;

    cmd_t    cmd;
    status_t st;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // controller walks read, window update, mac, divide, output per result
    bfg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // line store, window, weight tables, mac pipe, divider, output register
    bfg_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_op      (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // a held result is never overwritten
    `BFG_ASSERT_SAME(a_no_overwrite, cmd.out_load, (!m_tvalid || m_tready), "result overwritten")
    // a pixel transfer always starts a busy sequence
    `BFG_ASSERT_NEXT(a_pixel_busy, (s_tvalid && s_tready && s_tuser == OP_PIXEL), !s_tready, "pixel not processed")
    // frame end comes only on the last result of a transfer
    `BFG_ASSERT_SAME(a_done_last, (m_tvalid && m_tuser[0]), m_tlast, "frame_done without tlast")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfg_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  SETTLE      = 200;    // well past the first-result latency
    localparam int  ITEM_BUDGET = 460;

    // one filtered output pixel as the block should report it
    typedef struct {
        logic [7:0]  pix;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
        logic        done;
    } filt_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // table_index[7:0], weight_value[23:8], pixel_value[31:24]
    logic [1:0]  s_tuser = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // filtered_pixel[7:0], out_row[19:8], out_col[30:20]
    logic        m_tlast;
    logic [0:0]  m_tuser;        // frame_done[0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    bilateral_filter_gray dut (.*);

    always #6 aclk = ~aclk;

    // filter model state: line store, weight tables, raster position, 9x9 window
    logic [7:0]  line_mem [SLOTS*MAX_WIDTH];
    logic [15:0] spatial_w [TAPS];
    logic [15:0] range_w [256];
    logic [10:0] pos_col;
    logic [12:0] pos_row;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [7:0]  window [TAPS][TAPS];   // window[k][t]: k columns back from newest, row tap t

    filt_out_t   pending_px[$];
    int          errors = 0;
    int          cycles = 0;
    int          items_sent = 0;
    bit          idle_on = 1'b1;

    // weighted mean over the window round its centre tap
    function automatic logic [7:0] window_mean();
        logic [7:0]           ctr;
        logic [7:0]           p;
        logic [7:0]           d;
        longint unsigned      num;
        longint unsigned      den;
        longint unsigned      w;
        ctr = window[RADIUS][RADIUS];
        num = 0;
        den = 0;
        for (int k = 0; k < TAPS; k++) begin
            for (int t = 0; t < TAPS; t++) begin
                p = window[k][t];
                d = (p > ctr) ? p - ctr : ctr - p;
                w = longint'(spatial_w[2*RADIUS-k]) * longint'(spatial_w[t]);
                w = w * longint'(range_w[d]);
                num += w * p;
                den += w;
            end
        end
        if (den == 0) return ctr;
        return 8'(num / den);
    endfunction

    function automatic void shift_window(logic [7:0] newest [TAPS]);
        for (int k = TAPS - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = newest;
    endfunction

    // advance the model by one accepted input transfer, queue its output pixels
    function automatic void filter_step(op_t op, logic [7:0] idx, logic [15:0] wv,
                                        logic [7:0] pix);
        int          W;
        int          H;
        int          r;
        int          c;
        int          y;
        int          x;
        int          n;
        int          src;
        bit          fend;
        logic [7:0]  column [TAPS];
        filt_out_t   outs [8];
        n = 0;
        fend = 0;
        if (op == OP_SPATIAL) begin
            if (idx < TAPS) spatial_w[idx] = wv;
            return;
        end
        if (op == OP_RANGE) begin
            range_w[idx] = wv;
            return;
        end
        W = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        H = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        r = pos_row;
        c = pos_col;
        // flush inside the image does nothing
        if (op == OP_FLUSH && r < H) return;
        for (int t = 0; t < TAPS; t++) begin
            src = r - 2*RADIUS + t;
            if (src < 0) src = 0;
            if (src > H - 1) src = H - 1;
            column[t] = (src == r) ? pix : line_mem[(src % SLOTS)*MAX_WIDTH + c];
        end
        if (r < H) line_mem[(r % SLOTS)*MAX_WIDTH + c] = pix;
        if (c == 0) begin
            for (int k = 0; k < TAPS; k++) window[k] = column;
        end else begin
            shift_window(column);
        end
        y = r - RADIUS;
        if (y >= 0 && c >= RADIUS) begin
            outs[n] = '{window_mean(), 12'(y), 11'(c - RADIUS), 1'b0, 1'b0};
            n++;
        end
        // row end: replicate the last column to finish the row
        if (c >= W - 1) begin
            for (int k = 1; k <= RADIUS; k++) begin
                x = c - RADIUS + k;
                column = window[0];
                shift_window(column);
                if (y >= 0 && x >= 0) begin
                    outs[n] = '{window_mean(), 12'(y), 11'(x), 1'b0, 1'b0};
                    n++;
                end
            end
            fend = (r >= H - 1 + RADIUS);
            pos_col = '0;
            pos_row = fend ? '0 : 13'(r + 1);
        end else begin
            pos_col = 11'(c + 1);
        end
        if (n > 0) begin
            outs[n-1].last = 1'b1;
            outs[n-1].done = fend;
        end
        for (int i = 0; i < n; i++) pending_px = {pending_px, outs[i]};
    endfunction

    // one input transfer, entered and left at a falling edge
    task automatic send_item(op_t op, logic [7:0] idx, logic [15:0] wv, logic [7:0] pix);
        while (idle_on && $urandom_range(99) < 7) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {pix, wv, idx};
        do @(posedge aclk); while (!s_tready);
        filter_step(op, idx, wv, pix);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] pix);
        send_item(OP_PIXEL, 8'($urandom), 16'($urandom), pix);
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // let the block drain fully before touching registers
    task automatic wait_drained();
        while (pending_px.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_WIDTH) width_reg = val[11:0];
        else if (idx == CFG_HEIGHT) height_reg = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(int w, int h);
        wait_drained();
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
    endtask

    // rows r0..r1 of the current frame: pixels inside, flushes or pixels below;
    // noise adds ignored flushes and table reloads inside the image
    task automatic run_rows(int w, int h, int r0, int r1, bit noise);
        for (int r = r0; r <= r1; r++) begin
            for (int c = 0; c < w; c++) begin
                if (r < h) begin
                    if (noise && $urandom_range(99) < 5) send_flush();
                    if (noise && $urandom_range(99) < 3)
                        send_item(OP_RANGE, 8'($urandom), 16'($urandom), 8'($urandom));
                    send_pixel(8'($urandom));
                end else if ($urandom_range(99) < 30) begin
                    send_pixel(8'($urandom));
                end else begin
                    send_flush();
                end
            end
        end
    endtask

    task automatic load_spatial(bit zero, bit full);
        for (int i = 0; i < TAPS; i++)
            send_item(OP_SPATIAL, 8'(i),
                      zero ? 16'h0000 : full ? 16'hffff : 16'($urandom_range(1, 65535)),
                      8'($urandom));
    endtask

    task automatic test_weight_loads();
        load_spatial(0, 0);
        // out of range spatial indexes must leave the table alone
        send_item(OP_SPATIAL, 8'd9, 16'hffff, 8'h00);
        send_item(OP_SPATIAL, 8'd255, 16'h0000, 8'hff);
        for (int i = 0; i < 256; i++)
            send_item(OP_RANGE, 8'(i),
                      (i == 0) ? 16'hffff : (i == 255) ? 16'h0000 : 16'($urandom),
                      8'($urandom));
    endtask

    task automatic test_corner_sizes();
        set_size(1, 1);
        send_pixel(8'hff);
        run_rows(1, 1, 1, RADIUS, 0);
        // zero width and height behave as one
        set_size(0, 0);
        send_pixel(8'h00);
        run_rows(1, 1, 1, RADIUS, 0);
        set_size(2, 3);
        for (int r = 0; r < 3; r++) begin
            send_pixel(8'h00);
            send_pixel(8'hff);
        end
        run_rows(2, 3, 3, 3 + RADIUS - 1, 0);
    endtask

    task automatic test_zero_weight_sum();
        set_size(2, 2);
        load_spatial(1, 0);
        run_rows(2, 2, 0, 2 + RADIUS - 1, 0);
        load_spatial(0, 1);
        run_rows(2, 2, 0, 2 + RADIUS - 1, 0);
        load_spatial(0, 0);
    endtask

    task automatic test_widest_row();
        set_size(2048, 3);
        repeat (20) send_pixel(8'($urandom));
        // narrow in mid-row: the next pixel closes row 0
        wait_drained();
        write_reg(CFG_WIDTH, 13'd2);
        send_pixel(8'($urandom));
        run_rows(2, 3, 1, 3 + RADIUS - 1, 0);
    endtask

    task automatic test_tallest_frame();
        set_size(3, 4096);
        run_rows(3, 4096, 0, 2, 0);
        // cut the frame short below the current row
        set_size(3, 2);
        run_rows(3, 2, 3, 2 + RADIUS - 1, 0);
    endtask

    task automatic test_no_idling();
        set_size(3, 3);
        idle_on = 1'b0;
        run_rows(3, 3, 0, 3 + RADIUS - 1, 1);
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        while (items_sent < ITEM_BUDGET) begin
            w = ($urandom_range(4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            set_size(w, h);
            if ($urandom_range(3) == 0) load_spatial(0, 0);
            run_rows(w, h, 0, h + RADIUS - 1, 1);
        end
    endtask

    // result side: random stalls, sampled at the rising edge
    always @(negedge aclk)
        m_tready <= !(idle_on && $urandom_range(99) < 7);

    always @(posedge aclk) begin
        filt_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected result transfer data=%h last=%b done=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                e = pending_px.pop_front();
                if (m_tdata[7:0] !== e.pix) begin
                    $display("%0t: filtered_pixel expected %0d actual %0d (row %0d col %0d)",
                             $time, e.pix, m_tdata[7:0], e.row, e.col);
                    errors++;
                end
                if (m_tdata[19:8] !== e.row) begin
                    $display("%0t: out_row expected %0d actual %0d",
                             $time, e.row, m_tdata[19:8]);
                    errors++;
                end
                if (m_tdata[30:20] !== e.col) begin
                    $display("%0t: out_col expected %0d actual %0d",
                             $time, e.col, m_tdata[30:20]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== e.done) begin
                    $display("%0t: frame_done expected %b actual %b",
                             $time, e.done, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        pos_col    = '0;
        pos_row    = '0;
        width_reg  = 12'd640;
        height_reg = 13'd480;
        for (int k = 0; k < TAPS; k++)
            for (int t = 0; t < TAPS; t++) window[k][t] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_weight_loads();
        test_corner_sizes();
        test_zero_weight_sum();
        test_widest_row();
        test_tallest_frame();
        test_no_idling();
        test_random_frames();
        wait_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bfg_pkg.sv
hdl/bfg_ctrl.sv
hdl/bfg_datapath.sv
hdl/bilateral_filter_gray.sv
dv/tb.sv
